// ===== rtl/rpy_pkg.sv =====
// Shared constants, types and the arctangent table for the Y-axis point rotation block.
package rpy_pkg;

    // Coordinate and configuration widths
    localparam int C_COORD_W = 32;
    localparam int C_ANG_W   = 17;
    localparam int C_CFG_W   = 32;
    localparam int C_IDX_W   = 2;

    // Register indexes of the configuration port
    localparam logic [C_IDX_W-1:0] C_CFG_PIVOT_X = 2'd0;
    localparam logic [C_IDX_W-1:0] C_CFG_PIVOT_Z = 2'd1;
    localparam logic [C_IDX_W-1:0] C_CFG_ANGLE   = 2'd2;

    // Angle units: Q9.7 degrees
    localparam int C_DEG_FULL    = 46080;
    localparam int C_DEG_HALF    = 23040;
    localparam int C_DEG_QUARTER = 11520;
    localparam int C_NEG_W       = C_ANG_W + 1;
    localparam int C_FOLD_W      = 16;

    // Degree to Q2.30 radian scale and CORDIC start value
    localparam int C_RAD_PER_DEG = 18740330;
    localparam int C_RAD_W       = 26;
    localparam int C_PROD_RAD_W  = C_FOLD_W + C_RAD_W;
    localparam int C_RAD_SHIFT   = 7;
    localparam int C_GAIN_INV    = 652032874;

    // CORDIC datapath
    localparam int C_TRIG_ITERS = 16;
    localparam int C_ATAN_N     = 24;
    localparam int C_ITERS      = (C_TRIG_ITERS > C_ATAN_N) ? C_ATAN_N : C_TRIG_ITERS;
    localparam int C_ITER_W     = $clog2(C_ATAN_N);
    localparam int C_CW         = 34;
    localparam int C_ZW         = 33;
    localparam int C_TRIG_W     = 30;

    // Rotation datapath
    localparam int C_DIFF_W = C_COORD_W + 1;
    localparam int C_MUL_W  = C_DIFF_W + C_TRIG_W;
    localparam int C_SUM_W  = C_MUL_W + 1;
    localparam int C_RND_SH = 28;
    localparam int C_OFF_W  = C_SUM_W - C_RND_SH;
    localparam int C_RES_W  = C_OFF_W + 1;

    // Trig unit status and results toward the datapath
    typedef struct packed {
        logic                       busy;
        logic signed [C_TRIG_W-1:0] cs;
        logic signed [C_TRIG_W-1:0] sn;
    } t_trig;

    // round(atan(2^-i) * 2^30)
    function automatic logic signed [C_ZW-1:0] atan_q30(input logic [C_ITER_W-1:0] idx);
        logic signed [C_ZW-1:0] v;
        case (idx)
            5'd0:    v = 33'sd843314857;
            5'd1:    v = 33'sd497837829;
            5'd2:    v = 33'sd263043837;
            5'd3:    v = 33'sd133525159;
            5'd4:    v = 33'sd67021687;
            5'd5:    v = 33'sd33543516;
            5'd6:    v = 33'sd16775851;
            5'd7:    v = 33'sd8388437;
            5'd8:    v = 33'sd4194283;
            5'd9:    v = 33'sd2097149;
            5'd10:   v = 33'sd1048576;
            5'd11:   v = 33'sd524288;
            5'd12:   v = 33'sd262144;
            5'd13:   v = 33'sd131072;
            5'd14:   v = 33'sd65536;
            5'd15:   v = 33'sd32768;
            5'd16:   v = 33'sd16384;
            5'd17:   v = 33'sd8192;
            5'd18:   v = 33'sd4096;
            5'd19:   v = 33'sd2048;
            5'd20:   v = 33'sd1024;
            5'd21:   v = 33'sd512;
            5'd22:   v = 33'sd256;
            5'd23:   v = 33'sd128;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/rpy_trig.sv =====
// Iterative CORDIC that turns the negated configured angle into Q28 cosine and sine.
module rpy_trig
    import rpy_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [C_ANG_W-1:0] i_angle,
    output t_trig                     o_trig
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCALE,
        ST_RAD,
        ST_ITER,
        ST_DONE
    } t_state;

    t_state                         r_state;
    logic                           r_flip;
    logic signed [C_FOLD_W-1:0]     r_fold;
    logic signed [C_PROD_RAD_W-1:0] r_prod;
    logic signed [C_CW-1:0]         r_x;
    logic signed [C_CW-1:0]         r_y;
    logic signed [C_ZW-1:0]         r_z;
    logic [C_ITER_W-1:0]            r_iter;
    logic signed [C_TRIG_W-1:0]     r_cs;
    logic signed [C_TRIG_W-1:0]     r_sn;

    logic signed [C_NEG_W-1:0]      neg_ang;
    logic signed [C_NEG_W-1:0]      wrap_ang;
    logic signed [C_FOLD_W-1:0]     n_fold;
    logic                           n_flip;
    logic signed [C_PROD_RAD_W-1:0] rad_rnd;
    logic signed [C_CW-1:0]         sh_x;
    logic signed [C_CW-1:0]         sh_y;
    logic signed [C_CW-1:0]         n_x;
    logic signed [C_CW-1:0]         n_y;
    logic signed [C_ZW-1:0]         n_z;
    logic signed [C_CW-1:0]         fin_x;
    logic signed [C_CW-1:0]         fin_y;
    logic signed [C_CW-1:0]         rnd_x;
    logic signed [C_CW-1:0]         rnd_y;

    // Negate, wrap into [-180, 180), fold into [-90, 90]
    always_comb begin
        neg_ang = C_NEG_W'(0) - C_NEG_W'(i_angle);
        if (neg_ang >= C_NEG_W'(C_DEG_HALF)) begin
            wrap_ang = neg_ang - C_NEG_W'(C_DEG_FULL);
        end else if (neg_ang < -C_NEG_W'(C_DEG_HALF)) begin
            wrap_ang = neg_ang + C_NEG_W'(C_DEG_FULL);
        end else begin
            wrap_ang = neg_ang;
        end
        n_flip = 1'b1;
        if (wrap_ang > C_NEG_W'(C_DEG_QUARTER)) begin
            n_fold = C_FOLD_W'(wrap_ang - C_NEG_W'(C_DEG_HALF));
        end else if (wrap_ang < -C_NEG_W'(C_DEG_QUARTER)) begin
            n_fold = C_FOLD_W'(wrap_ang + C_NEG_W'(C_DEG_HALF));
        end else begin
            n_fold = C_FOLD_W'(wrap_ang);
            n_flip = 1'b0;
        end
    end

    // One rotation-mode step per cycle, plus the radian rounding and the final flip and Q28 rounding
    always_comb begin
        rad_rnd = (r_prod + C_PROD_RAD_W'(64)) >>> C_RAD_SHIFT;
        sh_x    = r_x >>> r_iter;
        sh_y    = r_y >>> r_iter;
        if (!r_z[C_ZW-1]) begin
            n_x = r_x - sh_y;
            n_y = r_y + sh_x;
            n_z = r_z - atan_q30(r_iter);
        end else begin
            n_x = r_x + sh_y;
            n_y = r_y - sh_x;
            n_z = r_z + atan_q30(r_iter);
        end
        fin_x = r_flip ? -r_x : r_x;
        fin_y = r_flip ? -r_y : r_y;
        rnd_x = (fin_x + C_CW'(2)) >>> 2;
        rnd_y = (fin_y + C_CW'(2)) >>> 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_REDUCE;
            r_iter  <= '0;
        end else if (i_start) begin
            r_state <= ST_REDUCE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_state <= ST_IDLE;
                end
                ST_REDUCE: begin
                    r_fold  <= n_fold;
                    r_flip  <= n_flip;
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_prod  <= C_PROD_RAD_W'(r_fold) * C_PROD_RAD_W'(C_RAD_PER_DEG);
                    r_state <= ST_RAD;
                end
                ST_RAD: begin
                    r_z     <= C_ZW'(rad_rnd);
                    r_x     <= C_CW'(C_GAIN_INV);
                    r_y     <= '0;
                    r_iter  <= '0;
                    r_state <= ST_ITER;
                end
                ST_ITER: begin
                    r_x    <= n_x;
                    r_y    <= n_y;
                    r_z    <= n_z;
                    r_iter <= r_iter + C_ITER_W'(1);
                    if (r_iter == C_ITER_W'(C_ITERS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_cs    <= C_TRIG_W'(rnd_x);
                    r_sn    <= C_TRIG_W'(rnd_y);
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_trig.busy = (r_state != ST_IDLE);
    assign o_trig.cs   = r_cs;
    assign o_trig.sn   = r_sn;

endmodule

// ===== rtl/rotate_point_about_y_axis.sv =====
// Top level: rotates a stream of 3D points about a vertical axis through a configured pivot.
//
//  channel  direction  handshake                     payload
//  -------  ---------  ----------------------------  ----------------------------------
//  in       in         i_in_valid / o_in_stall       i_in_x, i_in_y, i_in_z   (Q16.16)
//  out      out        o_out_valid / i_out_stall     o_out_x, o_out_y, o_out_z (Q16.16)
//  cfg      in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One transaction per cycle while o_in_stall is low, through a four-stage pipeline
// (difference, products, sum and round, pivot add and saturate).
// Sine and cosine are per-configuration: after reset the CORDIC sequencer runs with
// o_in_stall high; after each angle write o_in_stall is high from the registered
// start pulse until the sequencer is done.
// A stalled output holding a valid result freezes every stage; valid bits travel with the data, so nothing
// is lost or repeated, and a new transaction enters while a result waits unless the
// output register itself is held.
module rotate_point_about_y_axis
    import rpy_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_we,
    input  logic [C_IDX_W-1:0]          i_cfg_idx,
    input  logic [C_CFG_W-1:0]          i_cfg_data,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [C_COORD_W-1:0] i_in_x,
    input  logic signed [C_COORD_W-1:0] i_in_y,
    input  logic signed [C_COORD_W-1:0] i_in_z,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [C_COORD_W-1:0] o_out_x,
    output logic signed [C_COORD_W-1:0] o_out_y,
    output logic signed [C_COORD_W-1:0] o_out_z
);

    // Configuration registers
    logic signed [C_COORD_W-1:0] r_pivot_x;
    logic signed [C_COORD_W-1:0] r_pivot_z;
    logic signed [C_ANG_W-1:0]   r_angle;
    logic                        r_trig_start;

    // Pipeline stage registers
    logic                        r1_v;
    logic signed [C_DIFF_W-1:0]  r1_dx;
    logic signed [C_DIFF_W-1:0]  r1_dz;
    logic signed [C_COORD_W-1:0] r1_y;

    logic                        r2_v;
    logic signed [C_MUL_W-1:0]   r2_xc;
    logic signed [C_MUL_W-1:0]   r2_zs;
    logic signed [C_MUL_W-1:0]   r2_xs;
    logic signed [C_MUL_W-1:0]   r2_zc;
    logic signed [C_COORD_W-1:0] r2_y;

    logic                        r3_v;
    logic signed [C_OFF_W-1:0]   r3_xoff;
    logic signed [C_OFF_W-1:0]   r3_zoff;
    logic signed [C_COORD_W-1:0] r3_y;

    logic                        r4_v;
    logic signed [C_COORD_W-1:0] r4_x;
    logic signed [C_COORD_W-1:0] r4_y;
    logic signed [C_COORD_W-1:0] r4_z;

    t_trig                       trig;
    logic                        adv;
    logic                        in_acc;
    logic signed [C_SUM_W-1:0]   sum_x;
    logic signed [C_SUM_W-1:0]   sum_z;
    logic signed [C_RES_W-1:0]   res_x;
    logic signed [C_RES_W-1:0]   res_z;

    function automatic logic signed [C_COORD_W-1:0] sat_coord(
        input logic signed [C_RES_W-1:0] v
    );
        logic signed [C_COORD_W-1:0] r;
        if (v > $signed(C_RES_W'({1'b0, {(C_COORD_W-1){1'b1}}}))) begin
            r = {1'b0, {(C_COORD_W-1){1'b1}}};
        end else if (v < -$signed(C_RES_W'({1'b0, 1'b1, {(C_COORD_W-1){1'b0}}}))) begin
            r = {1'b1, {(C_COORD_W-1){1'b0}}};
        end else begin
            r = C_COORD_W'(v);
        end
        return r;
    endfunction

    // Hold every stage while the output register is full and stalled
    assign adv        = !(r4_v && i_out_stall);
    // Hold the input while the pipeline is held, and from the cycle after an angle write until fresh trig values land
    assign o_in_stall = !adv || trig.busy || r_trig_start;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Configuration writes; an angle write restarts the trig sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot_x    <= '0;
            r_pivot_z    <= '0;
            r_angle      <= '0;
            r_trig_start <= 1'b0;
        end else begin
            r_trig_start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    C_CFG_PIVOT_X: r_pivot_x <= C_COORD_W'(i_cfg_data);
                    C_CFG_PIVOT_Z: r_pivot_z <= C_COORD_W'(i_cfg_data);
                    C_CFG_ANGLE: begin
                        r_angle      <= C_ANG_W'(i_cfg_data);
                        r_trig_start <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    rpy_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_trig_start),
        .i_angle (r_angle),
        .o_trig  (trig)
    );

    // Rounded rotated offsets: round half up, then drop the Q28 fraction; pivot added back for stage 4
    always_comb begin
        sum_x = C_SUM_W'(r2_xc) - C_SUM_W'(r2_zs) + (C_SUM_W'(1) <<< (C_RND_SH - 1));
        sum_z = C_SUM_W'(r2_xs) + C_SUM_W'(r2_zc) + (C_SUM_W'(1) <<< (C_RND_SH - 1));
        res_x = C_RES_W'(r3_xoff) + C_RES_W'(r_pivot_x);
        res_z = C_RES_W'(r3_zoff) + C_RES_W'(r_pivot_z);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (adv) begin
            r1_v <= in_acc;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // Payload: advance all stages together
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // Stage 1: offsets from the pivot at full width
            r1_dx <= C_DIFF_W'(i_in_x) - C_DIFF_W'(r_pivot_x);
            r1_dz <= C_DIFF_W'(i_in_z) - C_DIFF_W'(r_pivot_z);
            r1_y  <= i_in_y;
            // Stage 2: the four products
            r2_xc <= C_MUL_W'(r1_dx) * C_MUL_W'(trig.cs);
            r2_zs <= C_MUL_W'(r1_dz) * C_MUL_W'(trig.sn);
            r2_xs <= C_MUL_W'(r1_dx) * C_MUL_W'(trig.sn);
            r2_zc <= C_MUL_W'(r1_dz) * C_MUL_W'(trig.cs);
            r2_y  <= r1_y;
            // Stage 3: sum and round
            r3_xoff <= sum_x[C_SUM_W-1:C_RND_SH];
            r3_zoff <= sum_z[C_SUM_W-1:C_RND_SH];
            r3_y    <= r2_y;
            // Stage 4: translate back and saturate
            r4_x <= sat_coord(res_x);
            r4_z <= sat_coord(res_z);
            r4_y <= r3_y;
        end
    end

    assign o_out_valid = r4_v;
    assign o_out_x     = r4_x;
    assign o_out_y     = r4_y;
    assign o_out_z     = r4_z;

endmodule
